FILE: design/rav_pkg.sv
// ----------------------------------------------------------------------------
// rav_pkg: shared types and constants for the resource address validator
// Character codes, resource type codes, address position codes and character class functions used by the checker.
// ----------------------------------------------------------------------------
package rav_pkg;

    typedef logic [7:0] char_t;
    typedef logic [3:0] rtype_t;
    typedef logic [1:0] pos_t;

    localparam char_t CH_COLON = 8'd58;
    localparam char_t CH_UNDER = 8'h5F;
    localparam char_t CH_SLASH = 8'h2F;
    localparam char_t CH_DOT   = 8'h2E;
    localparam char_t CH_LA    = 8'h61;
    localparam char_t CH_LE    = 8'h65;
    localparam char_t CH_LM    = 8'h6D;
    localparam char_t CH_LR    = 8'h72;
    localparam char_t CH_LW    = 8'h77;
    localparam char_t CH_LZ    = 8'h7A;
    localparam char_t CH_UA    = 8'h41;
    localparam char_t CH_UZ    = 8'h5A;
    localparam char_t CH_D0    = 8'h30;
    localparam char_t CH_D9    = 8'h39;

    localparam rtype_t RT_BLOB      = 4'd0;
    localparam rtype_t RT_MESH      = 4'd1;
    localparam rtype_t RT_TEXTURE2D = 4'd2;
    localparam rtype_t RT_WORLD     = 4'd3;
    localparam rtype_t RT_GEN_LO    = 4'd4;
    localparam rtype_t RT_GEN_HI    = 4'd9;

    localparam pos_t POS_LEAD  = 2'd0;
    localparam pos_t POS_COLON = 2'd1;
    localparam pos_t POS_BODY  = 2'd2;

    function automatic logic is_letter(input char_t c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function automatic logic is_plain(input char_t c);
        return is_letter(c) || (c >= CH_D0 && c <= CH_D9) || c == CH_UNDER;
    endfunction

endpackage

FILE: design/resource_address_validator.sv
// Path: a transfer in is registered, then checked; a verdict passes the input
//   register and then the result register on its way to the master side.
// Throughput: one character per cycle, limited only by the result register
//   draining (the input register and result register form a two-stage pipe).
// Reset: synchronous active-low aresetn clears both valid flags and the
//   address tracking state; the held type returns to blob.
// ----------------------------------------------------------------------------
// resource_address_validator
// Checks a streamed resource address character by character and emits one
// valid/invalid verdict on the character marked last.
// ----------------------------------------------------------------------------
module resource_address_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic [4:0] s_tuser,   // [3:0] resource_type, [4] first
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);

    // input register
    logic                in_vld_reg;
    rav_pkg::char_t      in_ch_reg;
    rav_pkg::rtype_t     in_type_reg;
    logic                in_first_reg;
    logic                in_last_reg;

    // address state
    rav_pkg::pos_t       pos_reg,   pos_next;
    rav_pkg::rtype_t     type_reg,  type_next;
    rav_pkg::char_t      lead_reg,  lead_next;
    rav_pkg::char_t      prev_reg,  prev_next;
    logic [1:0]          slash_reg, slash_next;
    logic                ok_reg,    ok_next;

    // result register
    logic                out_vld_reg;
    logic                out_res_reg, out_res_next;

    logic                out_free;
    logic                advance;

    rav_pkg::pos_t       pos_cur;
    rav_pkg::char_t      lead_cur;
    rav_pkg::char_t      prev_cur;
    logic [1:0]          slash_cur;
    logic                ok_cur;
    logic                slash_ok;
    logic                char_ok;
    logic                type_ok;

    assign out_free = !out_vld_reg || m_tready;
    // an item without last needs no room in the result register
    assign advance  = in_vld_reg && (!in_last_reg || out_free);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_ch_reg    <= s_tdata;
            in_type_reg  <= s_tuser[3:0];
            in_first_reg <= s_tuser[4];
            in_last_reg  <= s_tlast;
        end
    end

    always_comb begin
        type_next = in_first_reg ? in_type_reg : type_reg;
        pos_cur   = in_first_reg ? rav_pkg::POS_LEAD : pos_reg;
        lead_cur  = in_first_reg ? '0 : lead_reg;
        prev_cur  = in_first_reg ? '0 : prev_reg;
        slash_cur = in_first_reg ? 2'd0 : slash_reg;
        ok_cur    = in_first_reg ? 1'b1 : ok_reg;

        slash_ok = type_next == rav_pkg::RT_BLOB || type_next == rav_pkg::RT_MESH ||
                   (type_next == rav_pkg::RT_TEXTURE2D && lead_cur == rav_pkg::CH_LE);
        char_ok  = rav_pkg::is_plain(in_ch_reg) ||
                   (in_ch_reg == rav_pkg::CH_SLASH && slash_ok) ||
                   (in_ch_reg == rav_pkg::CH_DOT && type_next == rav_pkg::RT_BLOB);

        lead_next  = lead_cur;
        slash_next = slash_cur;
        ok_next    = ok_cur;
        case (pos_cur)
            rav_pkg::POS_LEAD: begin
                lead_next = in_ch_reg;
                if (!rav_pkg::is_letter(in_ch_reg)) ok_next = 1'b0;
            end
            rav_pkg::POS_COLON: begin
                if (in_ch_reg != rav_pkg::CH_COLON) ok_next = 1'b0;
            end
            default: begin
                if (!char_ok) ok_next = 1'b0;
                if (in_ch_reg == rav_pkg::CH_SLASH && slash_cur != 2'd2)
                    slash_next = slash_cur + 2'd1;
                // blob forbids "..", "./" and "//"
                if (type_next == rav_pkg::RT_BLOB &&
                    ((prev_cur == rav_pkg::CH_DOT &&
                      (in_ch_reg == rav_pkg::CH_DOT || in_ch_reg == rav_pkg::CH_SLASH)) ||
                     (prev_cur == rav_pkg::CH_SLASH && in_ch_reg == rav_pkg::CH_SLASH)))
                    ok_next = 1'b0;
            end
        endcase
        prev_next = in_ch_reg;
        pos_next  = (pos_cur == rav_pkg::POS_BODY) ? pos_cur : pos_cur + 2'd1;

        case (type_next)
            rav_pkg::RT_BLOB:      type_ok = lead_next == rav_pkg::CH_LR;
            rav_pkg::RT_MESH:      type_ok = lead_next == rav_pkg::CH_LM && slash_next <= 2'd1;
            rav_pkg::RT_TEXTURE2D: type_ok = lead_next == rav_pkg::CH_LA ||
                                             (lead_next == rav_pkg::CH_LE && slash_next <= 2'd1);
            rav_pkg::RT_WORLD:     type_ok = lead_next == rav_pkg::CH_LW;
            default: begin
                type_ok = type_next >= rav_pkg::RT_GEN_LO && type_next <= rav_pkg::RT_GEN_HI &&
                          lead_next == rav_pkg::CH_LA;
            end
        endcase
        out_res_next = ok_next && pos_next == rav_pkg::POS_BODY && type_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= rav_pkg::POS_LEAD;
            type_reg    <= rav_pkg::RT_BLOB;
            lead_reg    <= '0;
            prev_reg    <= '0;
            slash_reg   <= 2'd0;
            ok_reg      <= 1'b1;
            out_vld_reg <= 1'b0;
        end else begin
            if (advance && in_last_reg) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (advance) begin
                type_reg <= type_next;
                if (in_last_reg) begin
                    // verdict issued: clear the address, keep the type
                    pos_reg     <= rav_pkg::POS_LEAD;
                    lead_reg    <= '0;
                    prev_reg    <= '0;
                    slash_reg   <= 2'd0;
                    ok_reg      <= 1'b1;
                end else begin
                    pos_reg   <= pos_next;
                    lead_reg  <= lead_next;
                    prev_reg  <= prev_next;
                    slash_reg <= slash_next;
                    ok_reg    <= ok_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_res_reg};

endmodule

FILE: bench/tb_resource_address_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resource_address_validator
// Streams resource addresses into the validator and checks every verdict
// against a cycle-free predictor of the per-type address rules, under random
// source gaps, sink stalls and one long output stall.
// ----------------------------------------------------------------------------
module tb_resource_address_validator;

    localparam rav_pkg::rtype_t RT_UNDEF_LO = 4'd10;
    localparam rav_pkg::rtype_t RT_UNDEF_HI = 4'd15;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] ch
    logic [4:0] s_tuser  = 5'h00;   // [3:0] resource_type, [4] first
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] valid_res, [7:1] zero

    // predictor state
    rav_pkg::pos_t   addr_pos   = rav_pkg::POS_LEAD;
    rav_pkg::rtype_t held_type  = rav_pkg::RT_BLOB;
    rav_pkg::char_t  lead_ch    = 8'h00;
    rav_pkg::char_t  prev_ch    = 8'h00;
    logic [1:0]      slash_seen = 2'd0;
    bit              rules_ok   = 1'b1;

    bit expected_verdicts[$];
    int fault_cnt    = 0;
    int item_cnt     = 0;
    int hold_request = 0;
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;

    resource_address_validator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit letter_char(input rav_pkg::char_t c);
        return (c >= rav_pkg::CH_LA && c <= rav_pkg::CH_LZ) ||
               (c >= rav_pkg::CH_UA && c <= rav_pkg::CH_UZ);
    endfunction

    function automatic bit plain_char(input rav_pkg::char_t c);
        return letter_char(c) || (c >= rav_pkg::CH_D0 && c <= rav_pkg::CH_D9) ||
               c == rav_pkg::CH_UNDER;
    endfunction

    function automatic void clear_address();
        addr_pos   = rav_pkg::POS_LEAD;
        lead_ch    = 8'h00;
        prev_ch    = 8'h00;
        slash_seen = 2'd0;
        rules_ok   = 1'b1;
    endfunction

    // Advance the address state by one accepted character; queue a verdict on last.
    function automatic void predict_char(input rav_pkg::char_t c, input rav_pkg::rtype_t rt,
                                         input bit mark_first, input bit mark_last);
        bit body_ok;
        bit type_ok;
        if (mark_first) begin
            clear_address();
            held_type = rt;
        end
        case (addr_pos)
            rav_pkg::POS_LEAD: begin
                lead_ch = c;
                if (!letter_char(c)) rules_ok = 1'b0;
            end
            rav_pkg::POS_COLON: begin
                if (c != rav_pkg::CH_COLON) rules_ok = 1'b0;
            end
            default: begin
                body_ok = plain_char(c) ||
                          (c == rav_pkg::CH_SLASH && (held_type == rav_pkg::RT_BLOB ||
                           held_type == rav_pkg::RT_MESH ||
                           (held_type == rav_pkg::RT_TEXTURE2D &&
                            lead_ch == rav_pkg::CH_LE))) ||
                          (c == rav_pkg::CH_DOT && held_type == rav_pkg::RT_BLOB);
                if (!body_ok) rules_ok = 1'b0;
                if (c == rav_pkg::CH_SLASH && slash_seen < 2'd2) slash_seen++;
                if (held_type == rav_pkg::RT_BLOB &&
                    ((prev_ch == rav_pkg::CH_DOT &&
                      (c == rav_pkg::CH_DOT || c == rav_pkg::CH_SLASH)) ||
                     (prev_ch == rav_pkg::CH_SLASH && c == rav_pkg::CH_SLASH)))
                    rules_ok = 1'b0;
            end
        endcase
        prev_ch = c;
        if (addr_pos != rav_pkg::POS_BODY) addr_pos++;
        if (mark_last) begin
            case (held_type)
                rav_pkg::RT_BLOB: type_ok = lead_ch == rav_pkg::CH_LR;
                rav_pkg::RT_MESH: type_ok = lead_ch == rav_pkg::CH_LM && slash_seen <= 2'd1;
                rav_pkg::RT_TEXTURE2D: begin
                    type_ok = lead_ch == rav_pkg::CH_LA ||
                              (lead_ch == rav_pkg::CH_LE && slash_seen <= 2'd1);
                end
                rav_pkg::RT_WORLD: type_ok = lead_ch == rav_pkg::CH_LW;
                default: begin
                    type_ok = held_type >= rav_pkg::RT_GEN_LO &&
                              held_type <= rav_pkg::RT_GEN_HI &&
                              lead_ch == rav_pkg::CH_LA;
                end
            endcase
            expected_verdicts.push_back(rules_ok && addr_pos == rav_pkg::POS_BODY && type_ok);
            clear_address();
        end
    endfunction

    function automatic void note_fault(input string msg);
        if (fault_cnt < 10) $display("mismatch at %0t: %s", $realtime, msg);
        fault_cnt++;
    endfunction

    // sink: random stall bursts, plus a long hold when a test asks for one
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : verdict_check
        bit want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                note_fault($sformatf("unexpected verdict, tdata=%h", m_tdata));
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tdata !== {7'b0, want})
                    note_fault($sformatf("verdict expected %h actual %h",
                                         {7'b0, want}, m_tdata));
            end
        end
    end

    task automatic send_char(input rav_pkg::char_t c, input rav_pkg::rtype_t rt,
                             input bit mark_first, input bit mark_last);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= {mark_first, rt};
        s_tlast  <= mark_last;
        do @(posedge aclk); while (!s_tready);
        predict_char(c, rt, mark_first, mark_last);
        item_cnt++;
    endtask

    task automatic send_address(input string txt, input rav_pkg::rtype_t rt,
                                input bit mark_first = 1'b1, input bit mark_last = 1'b1);
        for (int i = 0; i < txt.len(); i++)
            send_char(rav_pkg::char_t'(txt[i]), rt, mark_first && i == 0,
                      mark_last && i == txt.len() - 1);
    endtask

    task automatic wait_verdicts_drained();
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic rav_pkg::char_t pick_body_char();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: return rav_pkg::char_t'(rav_pkg::CH_LA + $urandom_range(0, 25));
            6, 7:             return rav_pkg::char_t'(rav_pkg::CH_UA + $urandom_range(0, 25));
            8, 9:             return rav_pkg::char_t'(rav_pkg::CH_D0 + $urandom_range(0, 9));
            10:               return rav_pkg::CH_UNDER;
            11, 12, 13:       return rav_pkg::CH_SLASH;
            14, 15, 16:       return rav_pkg::CH_DOT;
            17:               return rav_pkg::CH_COLON;
            default:          return rav_pkg::char_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic rav_pkg::char_t pick_lead(input rav_pkg::rtype_t rt);
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ?
                   rav_pkg::char_t'($urandom_range(0, 255)) :
                   rav_pkg::char_t'(rav_pkg::CH_LA + $urandom_range(0, 25));
        case (rt)
            rav_pkg::RT_BLOB:      return rav_pkg::CH_LR;
            rav_pkg::RT_MESH:      return rav_pkg::CH_LM;
            rav_pkg::RT_TEXTURE2D: return $urandom_range(0, 1) ? rav_pkg::CH_LA : rav_pkg::CH_LE;
            rav_pkg::RT_WORLD:     return rav_pkg::CH_LW;
            default:               return rav_pkg::CH_LA;
        endcase
    endfunction

    // Mostly well-formed addresses; sometimes a missing first mark, an aborted
    // address, a bad colon or a one-character address.
    task automatic send_random_address();
        rav_pkg::rtype_t rt;
        bit              mark_first;
        bit              cut_short;
        int              body_len;
        rav_pkg::char_t  seq[$];
        rt = ($urandom_range(0, 7) == 0) ? rav_pkg::rtype_t'($urandom_range(0, 15))
                                         : rav_pkg::rtype_t'($urandom_range(0, 9));
        mark_first = $urandom_range(0, 11) != 0;
        cut_short  = $urandom_range(0, 11) == 0;
        body_len   = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, 6);
        seq.push_back(pick_lead(mark_first ? rt : held_type));
        if (body_len >= 0) begin
            seq.push_back(($urandom_range(0, 9) == 0) ?
                          rav_pkg::char_t'($urandom_range(0, 255)) : rav_pkg::CH_COLON);
            repeat (body_len) seq.push_back(pick_body_char());
        end
        // the type field only matters on the first character
        foreach (seq[i])
            send_char(seq[i], (i == 0) ? rt : rav_pkg::rtype_t'($urandom_range(0, 15)),
                      i == 0 && mark_first, i == seq.size() - 1 && !cut_short);
    endtask

    task automatic test_reset_defaults();
        // no first mark after reset: blob is held, the type field is ignored
        send_address("r:a", rav_pkg::RT_MESH, 1'b0);
    endtask

    task automatic test_type_rules();
        send_address("r:x.y/z", rav_pkg::RT_BLOB);
        send_address("r:a..b", rav_pkg::RT_BLOB);
        send_address("r://", rav_pkg::RT_BLOB);
        send_address("r:./", rav_pkg::RT_BLOB);
        send_address("r:/.", rav_pkg::RT_BLOB);
        send_address("R:a", rav_pkg::RT_BLOB);
        send_address("m:a/b", rav_pkg::RT_MESH);
        send_address("m:a/b/c", rav_pkg::RT_MESH);
        send_address("m:a.b", rav_pkg::RT_MESH);
        send_address("a:t/x", rav_pkg::RT_TEXTURE2D);
        send_address("e:t/x", rav_pkg::RT_TEXTURE2D);
        send_address("e:/x/", rav_pkg::RT_TEXTURE2D);
        send_address("w:Z_9", rav_pkg::RT_WORLD);
        send_address("w::", rav_pkg::RT_WORLD);
        send_address("wxy", rav_pkg::RT_WORLD);
        send_address("a:g", rav_pkg::RT_GEN_LO);
        send_address("a:g", rav_pkg::RT_GEN_HI);
        send_address("w:g", rav_pkg::RT_GEN_LO);
        send_address("a:g", RT_UNDEF_LO);
        send_address("a:g", RT_UNDEF_HI);
        send_address("w:", rav_pkg::RT_WORLD, 1'b1, 1'b0);
        send_char(8'hFF, rav_pkg::RT_WORLD, 1'b0, 1'b1);
        send_char(8'h00, RT_UNDEF_HI, 1'b1, 1'b1);
    endtask

    task automatic test_framing();
        send_address("a", rav_pkg::RT_GEN_LO);
        send_address("r:", rav_pkg::RT_BLOB);
        // restart inside an address drops it without a verdict
        send_address("m:x", rav_pkg::RT_MESH, 1'b1, 1'b0);
        send_address("w:y", rav_pkg::RT_WORLD);
        // no first mark after a verdict keeps the world type
        send_address("w:z", rav_pkg::RT_BLOB, 1'b0);
    endtask

    task automatic test_output_backpressure();
        wait_verdicts_drained();
        hold_request = 40;
        repeat (12) send_address("m:q", rav_pkg::RT_MESH);
        wait_verdicts_drained();
    endtask

    task automatic test_random_traffic();
        while (item_cnt < 350) send_random_address();
        wait_verdicts_drained();
        while (item_cnt < 640) send_random_address();
    endtask

    task automatic test_steady_stream();
        int stop_at;
        stop_at = item_cnt + 110;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (item_cnt < stop_at) send_random_address();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_type_rules();
        test_framing();
        test_output_backpressure();
        test_random_traffic();
        test_steady_stream();
        wait_verdicts_drained();
        if (fault_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
